>>> hdl/aac_rtp_au_depacketizer_assert.svh
// Assertion macros shared by the AAC RTP depacketizer RTL.
// Expects clk and rst_n in scope where used; no other dependencies.
`ifndef AAC_RTP_AU_DEPACKETIZER_ASSERT_SVH
`define AAC_RTP_AU_DEPACKETIZER_ASSERT_SVH

// Same-cycle implication.
`define AAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/aac_pkg.sv
// Shared constants and types for the AAC RTP access-unit depacketizer.
// No dependencies.
package aac_pkg;

    localparam int MAX_AU   = 64;
    localparam int ADTS_LEN = 7;
    localparam int STEP_MAX = 100;

    localparam int STAMP_W = 32;
    localparam int SIZE_W  = 13;
    localparam int FLEN_W  = 14;
    localparam int CNT_W   = $clog2(MAX_AU + 1);
    localparam int SLOT_AW = $clog2(MAX_AU);
    localparam int POS_W   = $clog2(2 * MAX_AU + 3);
    localparam int STEP_W  = $clog2(STEP_MAX + 1);
    localparam int LIM_W   = CNT_W + STEP_W;

    localparam logic [FLEN_W-1:0] FLEN_MAX  = '1;
    localparam logic [7:0]        LEAD_SYNC = 8'hFF;
    localparam logic [7:0]        LEAD_MASK = 8'hF0;

    typedef struct packed {
        logic               start;
        logic [STAMP_W-1:0] diff;
        logic [CNT_W-1:0]   count;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] step;
    } div_rsp_t;

endpackage

>>> hdl/aac_step_div.sv
// Iterative divider for the per-AU DTS increment: step = diff / count,
// zero when diff is negative or the quotient exceeds STEP_MAX. Uses aac_pkg.
module aac_step_div (
    input  logic              clk,
    input  logic              rst_n,
    input  aac_pkg::div_req_t req,
    output aac_pkg::div_rsp_t rsp
);
    import aac_pkg::*;

    localparam int BIT_W = $clog2(STEP_W);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

    dstate_t             state_reg, state_next;
    logic                done_reg, done_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [STAMP_W-1:0]  diff_reg, diff_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LIM_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   quo_reg, quo_next;
    logic [LIM_W-1:0]    limit;
    logic [LIM_W-1:0]    trial;

    // quotient exceeds STEP_MAX exactly when diff >= count * (STEP_MAX + 1)
    assign limit = LIM_W'(cnt_reg) * LIM_W'(STEP_MAX + 1);
    assign trial = LIM_W'(cnt_reg) << bit_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        bit_next   = bit_reg;
        diff_next  = diff_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    diff_next  = req.diff;
                    cnt_next   = req.count;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                quo_next = '0;
                if (diff_reg[STAMP_W-1] || (diff_reg >= STAMP_W'(limit)))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = diff_reg[LIM_W-1:0];
                    bit_next   = BIT_W'(STEP_W - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next          = rem_reg - trial;
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.step = quo_reg;

endmodule

>>> hdl/aac_rtp_au_depacketizer.sv
// AAC RTP (high-bit-rate AU header mode) depacketizer, top level.
// Uses aac_pkg, aac_step_div and the assertion macro header.
//
// Input channel: one RTP payload byte per transaction (payload_byte) with
// packet_first / packet_last marks; packet_stamp_ms is sampled on the first
// byte. A transaction completes when in_valid is high and in_stall is low.
// Output channel: one transaction per AU data byte (frame_byte). frame_end
// marks the last byte of a completed frame; frame_dts and adts_prefix are
// meaningful only then and read 0 otherwise.
// Each byte is taken into an input register, and the next cycle processes it
// against the AU size that was read from the size memory (separate write and
// read ports) in the accept cycle; no new byte is taken until it is processed.
// The byte that completes the AU header area also holds off the next byte
// while the iterative step divider runs (one quotient bit per cycle); the wait
// is shorter when the step is forced to zero by the range check.
// Each data byte passes from the input register to the output register, where
// it is presented; a full output keeps it waiting in the input register.
// A stalled output keeps its transaction; the block still takes the next byte
// and only waits if that byte also produces an output.
// Reset clears all parse, frame and stamp state; the size memory is not
// cleared, as every entry is written from the AU headers before it is read.
module aac_rtp_au_depacketizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  payload_byte,
    input  logic                        packet_first,
    input  logic                        packet_last,
    input  logic [aac_pkg::STAMP_W-1:0] packet_stamp_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  frame_byte,
    output logic                        frame_end,
    output logic [aac_pkg::STAMP_W-1:0] frame_dts,
    output logic                        adts_prefix
);
    import aac_pkg::*;

    `include "aac_rtp_au_depacketizer_assert.svh"

    localparam int DTS_PW = CNT_W + STEP_W;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV} state_t;

    state_t              state_reg, state_next;
    logic [POS_W-1:0]    bpos_reg, bpos_next;
    logic [7:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    slot_reg, slot_next;
    logic [SIZE_W-1:0]   taken_reg, taken_next;
    logic [FLEN_W-1:0]   flen_reg, flen_next;
    logic [15:0]         lead_reg, lead_next;
    logic [STAMP_W-1:0]  prev_reg, prev_next;
    logic [STAMP_W-1:0]  cur_reg, cur_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                skip_reg, skip_next;
    logic                out_valid_reg, out_valid_next;

    // accepted input transaction
    logic [7:0]          x_byte_reg;
    logic                x_first_reg;
    logic                x_last_reg;
    logic [STAMP_W-1:0]  x_stamp_reg;

    // output transaction payload
    logic [7:0]          o_byte_reg;
    logic                o_end_reg;
    logic [STAMP_W-1:0]  o_dts_reg;
    logic                o_adts_reg;

    // AU size memory
    logic [SIZE_W-1:0]   size_mem [MAX_AU];
    logic [SIZE_W-1:0]   size_rdata_reg;
    logic                mem_we;
    logic [SLOT_AW-1:0]  mem_waddr;
    logic [SIZE_W-1:0]   mem_wdata;
    logic                accept;

    aac_pkg::div_req_t   div_req;
    aac_pkg::div_rsp_t   div_rsp;

    // datapath terms
    logic [POS_W-1:0]    hend;
    logic [POS_W-1:0]    hoff;
    logic [POS_W-1:0]    bpos_inc;
    logic [15:0]         hword;
    logic [11:0]         hcount;
    logic                hcount_bad;
    logic [STAMP_W-1:0]  prev_seed;
    logic                data_phase;
    logic                produce;
    logic                out_busy;
    logic                out_load;
    logic [FLEN_W-1:0]   flen_inc;
    logic [15:0]         lead_upd;
    logic [SIZE_W-1:0]   taken_inc;
    logic [CNT_W-1:0]    slot_inc;
    logic                slot_close;
    logic                frame_done;
    logic [DTS_PW-1:0]   dts_off;
    logic [STAMP_W-1:0]  dts;
    logic                adts;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    assign hend       = POS_W'(2) + POS_W'({count_reg, 1'b0});
    assign hoff       = bpos_reg - POS_W'(2);
    assign bpos_inc   = bpos_reg + 1'b1;
    assign hword      = {hi_reg, x_byte_reg};
    assign hcount     = hword[15:4];
    assign hcount_bad = (hcount == '0) || (hcount > 12'(MAX_AU));
    assign prev_seed  = (prev_reg == '0) ? cur_reg : prev_reg;

    assign data_phase = !x_first_reg && (bpos_reg > POS_W'(1)) && (count_reg != '0)
                        && (bpos_reg >= hend);
    assign produce    = data_phase && !skip_reg && (slot_reg < count_reg)
                        && (size_rdata_reg != '0);
    assign out_busy   = out_valid_reg && out_stall;

    assign flen_inc   = (flen_reg != FLEN_MAX) ? flen_reg + 1'b1 : flen_reg;
    assign taken_inc  = taken_reg + 1'b1;
    assign slot_inc   = slot_reg + 1'b1;
    assign slot_close = (taken_inc >= size_rdata_reg) || x_last_reg;
    assign frame_done = slot_close && (flen_inc >= FLEN_W'(size_rdata_reg));
    assign dts_off    = DTS_PW'(slot_reg) * DTS_PW'(step_reg);
    assign dts        = prev_reg + STAMP_W'(dts_off);
    assign adts       = (lead_upd[15:8] == LEAD_SYNC)
                        && ((lead_upd[7:0] & LEAD_MASK) == LEAD_MASK)
                        && (flen_inc > FLEN_W'(ADTS_LEN));

    always_comb
    begin
        if (flen_reg == '0)
        begin
            lead_upd = {x_byte_reg, 8'h00};
        end
        else if (flen_reg == FLEN_W'(1))
        begin
            lead_upd = {lead_reg[15:8], x_byte_reg};
        end
        else
        begin
            lead_upd = lead_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        bpos_next     = bpos_reg;
        hi_next       = hi_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        taken_next    = taken_reg;
        flen_next     = flen_reg;
        lead_next     = lead_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        skip_next     = skip_reg;
        mem_we        = 1'b0;
        mem_waddr     = hoff[SLOT_AW:1];
        mem_wdata     = hword[15:3];
        div_req.start = 1'b0;
        div_req.diff  = cur_reg - prev_seed;
        div_req.count = count_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (x_first_reg)
                begin
                    bpos_next  = x_last_reg ? '0 : POS_W'(1);
                    hi_next    = x_byte_reg;
                    cur_next   = x_stamp_reg;
                    skip_next  = 1'b0;
                    count_next = '0;
                    slot_next  = '0;
                    taken_next = '0;
                    state_next = S_IDLE;
                end
                else if (bpos_reg == '0)
                begin
                    // stray byte outside a packet
                    state_next = S_IDLE;
                end
                else if (bpos_reg == POS_W'(1))
                begin
                    if (hcount_bad)
                    begin
                        skip_next  = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = CNT_W'(hcount);
                    end
                    bpos_next  = x_last_reg ? '0 : POS_W'(2);
                    state_next = S_IDLE;
                end
                else if (count_reg == '0)
                begin
                    if (x_last_reg)
                    begin
                        bpos_next = '0;
                    end
                    state_next = S_IDLE;
                end
                else if (bpos_reg < hend)
                begin
                    if (!hoff[0])
                    begin
                        hi_next = x_byte_reg;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                    bpos_next  = bpos_inc;
                    state_next = S_IDLE;
                    if (bpos_inc == hend)
                    begin
                        prev_next     = prev_seed;
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    if (x_last_reg)
                    begin
                        if (bpos_inc == hend)
                        begin
                            prev_next = cur_reg;
                        end
                        bpos_next = '0;
                    end
                end
                else if (!(produce && out_busy))
                begin
                    // AU data byte; holds here while the output is full
                    if (!skip_reg && (slot_reg < count_reg))
                    begin
                        if (size_rdata_reg == '0)
                        begin
                            skip_next = 1'b1;
                        end
                        else
                        begin
                            out_load   = 1'b1;
                            lead_next  = lead_upd;
                            flen_next  = flen_inc;
                            taken_next = taken_inc;
                            if (slot_close)
                            begin
                                if (frame_done)
                                begin
                                    flen_next = '0;
                                    lead_next = '0;
                                end
                                slot_next  = slot_inc;
                                taken_next = '0;
                                if (slot_inc >= count_reg)
                                begin
                                    skip_next = 1'b1;
                                end
                            end
                        end
                    end
                    if (x_last_reg)
                    begin
                        prev_next = cur_reg;
                        bpos_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_next  = div_rsp.step;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bpos_reg      <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            taken_reg     <= '0;
            flen_reg      <= '0;
            lead_reg      <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            step_reg      <= '0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bpos_reg      <= bpos_next;
            hi_reg        <= hi_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            taken_reg     <= taken_next;
            flen_reg      <= flen_next;
            lead_reg      <= lead_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_byte_reg  <= payload_byte;
            x_first_reg <= packet_first;
            x_last_reg  <= packet_last;
            x_stamp_reg <= packet_stamp_ms;
        end
        if (out_load)
        begin
            o_byte_reg <= x_byte_reg;
            o_end_reg  <= frame_done;
            o_dts_reg  <= frame_done ? dts : '0;
            o_adts_reg <= frame_done && adts;
        end
    end

    // size memory: header bytes write, accept cycle reads the current slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_rdata_reg <= size_mem[slot_reg[SLOT_AW-1:0]];
        end
    end

    aac_step_div u_step_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign frame_byte  = o_byte_reg;
    assign frame_end   = o_end_reg;
    assign frame_dts   = o_dts_reg;
    assign adts_prefix = o_adts_reg;

    `AAC_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC, "accepted byte not processed")
    `AAC_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_reg == S_DIV, "step result outside wait")
    `AAC_ASSERT_NOW(a_slot_bound, 1'b1, slot_reg <= count_reg, "slot index beyond AU count")
    `AAC_ASSERT_NOW(a_pos_bound, 1'b1, bpos_reg <= hend, "parse position beyond header end")

endmodule
